### rtl/core/blv_pkg.sv
// blv_pkg: shared types and constants for the bounded value list.
// Used by blv_store, blv_seq and bounded_list_with_value_removal_top.
// No dependencies.
package blv_pkg;

    localparam int DEPTH_DEF   = 16;
    localparam int DATA_W      = 32;
    localparam int CMD_W       = 3;
    localparam int COUNT_OUT_W = 5;

    localparam logic signed [DATA_W-1:0] EMPTY_MARK = -32'sd999;

    typedef enum logic [CMD_W-1:0] {
        CMD_APPEND     = 3'd0,
        CMD_POP_HEAD   = 3'd1,
        CMD_POP_TAIL   = 3'd2,
        CMD_REMOVE_VAL = 3'd3,
        CMD_CLEAR      = 3'd4
    } blv_cmd_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } blv_status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_LOOKUP,
        S_RESP
    } blv_state_t;

    typedef struct packed {
        logic        strobe;
        blv_status_t status;
        logic        empty;
    } blv_rsp_t;

endpackage

### rtl/core/blv_store.sv
// blv_store: entry memory, one write port and two registered read ports.
// Depends on blv_pkg.
module blv_store
    import blv_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    localparam int AW = $clog2(DEPTH)
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [AW-1:0]     wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic [AW-1:0]     rd_addr_a,
    input  logic [AW-1:0]     rd_addr_b,
    output logic [DATA_W-1:0] rd_data_a,
    output logic [DATA_W-1:0] rd_data_b
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_a_reg;
    logic [DATA_W-1:0] rd_data_b_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_a_reg <= mem[rd_addr_a];
        rd_data_b_reg <= mem[rd_addr_b];
    end

    assign rd_data_a = rd_data_a_reg;
    assign rd_data_b = rd_data_b_reg;

endmodule

### rtl/core/blv_seq.sv
// blv_seq: command sequencer with the shared compare/shift loop.
// Depends on blv_pkg; drives the ports of blv_store.
module blv_seq
    import blv_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    localparam int AW = $clog2(DEPTH),
    localparam int CW = $clog2(DEPTH + 1)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [CMD_W-1:0]  cmd,
    input  logic [DATA_W-1:0] value,
    input  logic [DATA_W-1:0] rd_data_a,
    output logic [AW-1:0]     rd_addr_a,
    output logic [AW-1:0]     rd_addr_b,
    output logic              wr_en,
    output logic [AW-1:0]     wr_addr,
    output logic [DATA_W-1:0] wr_data,
    output logic [CW-1:0]     count,
    output blv_rsp_t          rsp
);

    blv_state_t        state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    blv_status_t       status_reg, status_next;
    logic [DATA_W-1:0] value_reg, value_next;
    logic [CW-1:0]     idx_reg, idx_next;
    logic [AW-1:0]     tag_reg, tag_next;
    logic              pend_reg, pend_next;

    logic hit;
    logic last;
    logic src_ok;
    logic is_zero;
    logic is_full;

    // tag: index of the entry being compared (scan) or written (shift)
    assign hit     = pend_reg && (rd_data_a == value_reg);
    assign last    = pend_reg && ((CW'(tag_reg) + CW'(1)) == count_reg);
    assign src_ok  = idx_reg < count_reg;
    assign is_zero = count_reg == '0;
    assign is_full = count_reg == CW'(DEPTH);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        value_reg  <= value_next;
        idx_reg    <= idx_next;
        tag_reg    <= tag_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    unique case (blv_cmd_t'(cmd))
                        CMD_POP_HEAD:   state_next = is_zero ? S_LOOKUP : S_SHIFT;
                        CMD_REMOVE_VAL: state_next = is_zero ? S_LOOKUP : S_SCAN;
                        default:        state_next = S_LOOKUP;
                    endcase
                end
            end
            S_SCAN:
            begin
                priority if (hit)
                begin
                    state_next = S_SHIFT;
                end
                else if (last)
                begin
                    state_next = S_LOOKUP;
                end
            end
            S_SHIFT:  state_next = src_ok ? S_SHIFT : S_LOOKUP;
            S_LOOKUP: state_next = S_RESP;
            S_RESP:   state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        count_next  = count_reg;
        status_next = status_reg;
        value_next  = value_reg;
        idx_next    = idx_reg;
        tag_next    = tag_reg;
        pend_next   = pend_reg;
        wr_en       = 1'b0;
        wr_addr     = tag_reg;
        wr_data     = rd_data_a;
        rd_addr_a   = idx_reg[AW-1:0];
        rd_addr_b   = AW'(count_reg - CW'(1));
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    value_next  = value;
                    status_next = ST_OK;
                    pend_next   = 1'b0;
                    unique case (blv_cmd_t'(cmd))
                        CMD_APPEND:
                        begin
                            if (is_full)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                wr_addr    = count_reg[AW-1:0];
                                wr_data    = value;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        CMD_POP_HEAD:
                        begin
                            if (is_zero)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                idx_next = CW'(1);
                            end
                        end
                        CMD_POP_TAIL:
                        begin
                            if (is_zero)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                count_next = count_reg - CW'(1);
                            end
                        end
                        CMD_REMOVE_VAL:
                        begin
                            if (is_zero)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                idx_next = '0;
                            end
                        end
                        CMD_CLEAR: count_next = '0;
                        default:   ;
                    endcase
                end
            end
            S_SCAN:
            begin
                priority if (hit)
                begin
                    idx_next  = CW'(tag_reg) + CW'(1);
                    pend_next = 1'b0;
                end
                else if (last)
                begin
                    status_next = ST_NOT_FOUND;
                    pend_next   = 1'b0;
                end
                else
                begin
                    tag_next  = idx_reg[AW-1:0];
                    pend_next = 1'b1;
                    idx_next  = idx_reg + CW'(1);
                end
            end
            S_SHIFT:
            begin
                wr_en = pend_reg;
                if (src_ok)
                begin
                    tag_next  = AW'(idx_reg - CW'(1));
                    pend_next = 1'b1;
                    idx_next  = idx_reg + CW'(1);
                end
                else
                begin
                    pend_next  = 1'b0;
                    count_next = count_reg - CW'(1);
                end
            end
            S_LOOKUP:
            begin
                rd_addr_a = '0;
            end
            S_RESP:  ;
            default: ;
        endcase
    end

    assign busy       = state_reg != S_IDLE;
    assign count      = count_reg;
    assign rsp.strobe = state_reg == S_RESP;
    assign rsp.status = status_reg;
    assign rsp.empty  = is_zero;

`ifndef ASSERT_OFF
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted command did not raise busy");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.strobe && rsp.status == ST_FULL |-> is_full)
        else $error("full status with room left");

    a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.strobe && rsp.status == ST_EMPTY |-> is_zero)
        else $error("empty status on a non-empty list");

    a_wr_in_list: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> CW'(wr_addr) <= count_reg && count_reg <= CW'(DEPTH))
        else $error("write outside held entries");
`endif

endmodule

### rtl/core/bounded_list_with_value_removal_top.sv
// Top level of the bounded value list: sequencer plus entry memory.
// Depends on blv_pkg, blv_seq and blv_store.
//
//  beat      direction  handshake           payload
//  command   in         start & !busy       cmd, value
//  result    out        done (one cycle)    status, head_value, tail_value,
//                                           entry_count, is_empty
//
// Append, pop tail, clear, unused codes and removals on an empty list pass from
// accept through the lookup and response states to done. Pop head first runs
// the shift loop; remove value runs the compare loop and, on a hit, the shift
// loop. Both loops handle one entry per cycle.
// busy is high from the cycle after accept through the done cycle.
// Reset clears the count and sequencer; memory contents are not cleared.
// The result side cannot stall.
module bounded_list_with_value_removal_top
    import blv_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    localparam int AW = $clog2(DEPTH),
    localparam int CW = $clog2(DEPTH + 1)
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [CMD_W-1:0]         cmd,
    input  logic signed [DATA_W-1:0] value,
    output logic                     done,
    output logic [1:0]               status,
    output logic signed [DATA_W-1:0] head_value,
    output logic signed [DATA_W-1:0] tail_value,
    output logic [COUNT_OUT_W-1:0]   entry_count,
    output logic                     is_empty
);

    logic [DATA_W-1:0] rd_data_a;
    logic [DATA_W-1:0] rd_data_b;
    logic [AW-1:0]     rd_addr_a;
    logic [AW-1:0]     rd_addr_b;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [DATA_W-1:0] wr_data;
    logic [CW-1:0]     count;
    blv_rsp_t          rsp;

    blv_seq #(.DEPTH(DEPTH)) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .value     (value),
        .rd_data_a (rd_data_a),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .count     (count),
        .rsp       (rsp)
    );

    blv_store #(.DEPTH(DEPTH)) u_store (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

    assign done        = rsp.strobe;
    assign status      = rsp.status;
    assign is_empty    = rsp.empty;
    assign head_value  = rsp.empty ? EMPTY_MARK : signed'(rd_data_a);
    assign tail_value  = rsp.empty ? EMPTY_MARK : signed'(rd_data_b);
    assign entry_count = COUNT_OUT_W'(count);

endmodule
